### sv/assert_macros.svh
// Assertion macros for the three-wire bus master checker.
// Used by the checker file only; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define L3BM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define L3BM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### sv/l3bm_pkg.sv
// Shared types and constants of the three-wire bus master.
// No dependencies; every other file but assert_macros.svh imports this package.
`timescale 1ns / 1ps

package l3bm_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
    localparam int TIMER_WIDTH   = 16;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 3;

    localparam int Q_DEPTH       = 4;
    localparam int Q_PTR_W       = $clog2(Q_DEPTH);
    localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);

    // front stage + queue + back hold + output register
    localparam int INFLIGHT_MAX  = Q_DEPTH + 3;
    localparam int INFLIGHT_W    = $clog2(INFLIGHT_MAX + 1);

    localparam logic [1:0] BPOS_MAX = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_SETUP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_HOLD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HALT       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_GAP  = 3'd5;

    typedef enum logic [1:0] {
        OP_ADDR    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_READ    = 2'd2,
        OP_RELEASE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_ADDR    = 3'd1,
        CMD_WRITE   = 3'd2,
        CMD_READ    = 3'd3,
        CMD_RELEASE = 3'd4
    } cmd_t;

    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_HALT  = 7'b0000010,
        PH_SETUP = 7'b0000100,
        PH_GAP   = 7'b0001000,
        PH_LOW   = 7'b0010000,
        PH_HIGH  = 7'b0100000,
        PH_HOLD  = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic       start_req;
        logic [1:0] operation;
        logic [7:0] byte_out;
        logic       data_pin_in;
    } in_item_t;

    typedef struct packed {
        logic       mode_pin;
        logic       clock_pin;
        logic       data_pin;
        logic       pins_driven;
        logic       data_driven;
        logic       busy_res;
        logic       read_done;
        logic [7:0] read_byte;
    } out_item_t;

    typedef struct packed {
        cmd_t       kind;
        logic [7:0] byte_val;
        logic       din;
    } cmd_item_t;

    typedef struct packed {
        logic [TIMER_WIDTH-1:0] clock_low;
        logic [TIMER_WIDTH-1:0] clock_high;
        logic [TIMER_WIDTH-1:0] mode_setup;
        logic [TIMER_WIDTH-1:0] mode_hold;
        logic [TIMER_WIDTH-1:0] halt;
        logic [TIMER_WIDTH-1:0] write_gap;
    } cfg_t;

    typedef struct packed {
        phase_t                 phase;
        logic [TIMER_WIDTH-1:0] wait_cnt;
        logic [BIT_IDX_W-1:0]   bit_idx;
        logic [7:0]             shift;
        logic [1:0]             bpos;
        op_t                    op;
        logic                   lv_mode;
        logic                   lv_clock;
        logic                   lv_data;
        logic                   en_pins;
        logic                   en_data;
        logic [7:0]             rx;
        logic                   done;
    } st_t;

endpackage

### sv/l3bm_ifs.sv
// Valid/ready channel interfaces for the bus master's tick and result beats.
// Depends on l3bm_pkg for the payload types.
`timescale 1ns / 1ps

interface l3bm_in_if;
    import l3bm_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface l3bm_out_if;
    import l3bm_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/l3_bus_master_unit.sv
// Channel  | modport            | beat payload
// in_ch    | l3bm_in_if.sink    | one bus tick: start_req, operation, byte_out, data_pin_in
// out_ch   | l3bm_out_if.source | pin levels, drive enables, busy_res, read_done, read_byte
// cfg      | cfg_we/index/data  | six 16-bit timing registers, write only
// One tick beat per cycle sustained while results are taken and no phase is zero-length;
// each tick beat yields exactly one result beat. A beat passes the front decode register,
// the queue and the back sequencer into the result register. The back sequencer retires
// one phase exit per cycle through zero-length phases while the result register is free.
// Reset is asynchronous; all timing registers return to their defaults. A stalled
// result beat holds the sequencer; the four-entry queue keeps the front taking beats.
`timescale 1ns / 1ps

module l3_bus_master_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    l3bm_in_if.sink                        in_ch,
    l3bm_out_if.source                     out_ch,
    input  logic                           cfg_we,
    input  logic [l3bm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [l3bm_pkg::CFG_W-1:0]     cfg_data
);
    import l3bm_pkg::*;

    logic      fq_valid;
    logic      fq_ready;
    cmd_item_t fq_item;
    logic      qb_valid;
    logic      qb_pop;
    cmd_item_t qb_item;

    l3bm_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_ready (fq_ready),
        .q_valid (fq_valid),
        .q_item  (fq_item)
    );

    l3bm_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_item  (fq_item),
        .push_ready (fq_ready),
        .pop_valid  (qb_valid),
        .pop_item   (qb_item),
        .pop        (qb_pop)
    );

    l3bm_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (qb_valid),
        .q_item    (qb_item),
        .q_pop     (qb_pop),
        .out_ch    (out_ch)
    );

endmodule

### sv/l3bm_front.sv
// Front stage: takes tick beats and decodes them into command items.
// Depends on l3bm_pkg and l3bm_in_if.
`timescale 1ns / 1ps

module l3bm_front
(
    input  logic                clk,
    input  logic                rst_n,
    l3bm_in_if.sink             in_ch,
    input  logic                q_ready,
    output logic                q_valid,
    output l3bm_pkg::cmd_item_t q_item
);
    import l3bm_pkg::*;

    logic      stage_v_reg;
    logic      stage_v_next;
    cmd_item_t stage_reg;
    cmd_item_t stage_next;
    cmd_item_t decoded;
    logic      in_fire;

    always_comb
    begin
        decoded.byte_val = in_ch.data.byte_out;
        decoded.din      = in_ch.data.data_pin_in;
        decoded.kind     = CMD_NONE;
        if (in_ch.data.start_req)
        begin
            unique case (op_t'(in_ch.data.operation))
                OP_ADDR:    decoded.kind = CMD_ADDR;
                OP_WRITE:   decoded.kind = CMD_WRITE;
                OP_READ:    decoded.kind = CMD_READ;
                OP_RELEASE: decoded.kind = CMD_RELEASE;
                default:    decoded.kind = CMD_NONE;
            endcase
        end
    end

    assign in_ch.ready = !stage_v_reg || q_ready;
    assign in_fire     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        stage_next   = stage_reg;
        stage_v_next = stage_v_reg;
        if (in_fire)
        begin
            stage_next   = decoded;
            stage_v_next = 1'b1;
        end
        else if (q_ready)
        begin
            stage_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_v_reg <= 1'b0;
        end
        else
        begin
            stage_v_reg <= stage_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign q_valid = stage_v_reg;
    assign q_item  = stage_reg;

endmodule

### sv/l3bm_queue.sv
// Short FIFO of decoded command items between the front and back parts.
// Depends on l3bm_pkg.
`timescale 1ns / 1ps

module l3bm_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  l3bm_pkg::cmd_item_t push_item,
    output logic                push_ready,
    output logic                pop_valid,
    output l3bm_pkg::cmd_item_t pop_item,
    input  logic                pop
);
    import l3bm_pkg::*;

    cmd_item_t          entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               push_fire;
    logic               pop_fire;

    assign push_ready = count_reg != Q_CNT_W'(Q_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = push_fire ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_fire ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + Q_CNT_W'(push_fire) - Q_CNT_W'(pop_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### sv/l3bm_back.sv
// Back part: timing sequencer for the mode/clock/data lines, config registers
// and the result register. Depends on l3bm_pkg and l3bm_out_if.
`timescale 1ns / 1ps

module l3bm_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [l3bm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [l3bm_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          q_valid,
    input  l3bm_pkg::cmd_item_t           q_item,
    output logic                          q_pop,
    l3bm_out_if.source                    out_ch
);
    import l3bm_pkg::*;

    function automatic st_t ph_enter(st_t s, phase_t p, cfg_t c);
        st_t r;
        r       = s;
        r.phase = p;
        unique case (p)
            PH_HALT:
            begin
                r.lv_mode  = 1'b0;
                r.wait_cnt = c.halt;
            end
            PH_SETUP:
            begin
                r.lv_mode  = (s.op != OP_ADDR);
                r.wait_cnt = c.mode_setup;
            end
            PH_GAP:
            begin
                r.wait_cnt = c.write_gap;
            end
            PH_LOW:
            begin
                r.lv_clock = 1'b0;
                if (s.op != OP_READ)
                begin
                    r.lv_data = s.shift[s.bit_idx];
                end
                r.wait_cnt = c.clock_low;
            end
            PH_HIGH:
            begin
                r.lv_clock = 1'b1;
                r.wait_cnt = c.clock_high;
            end
            PH_HOLD:
            begin
                if (s.op == OP_ADDR)
                begin
                    r.lv_mode = 1'b1;
                end
                r.wait_cnt = c.mode_hold;
            end
            default:
            begin
                r.phase    = PH_IDLE;
                r.wait_cnt = '0;
            end
        endcase
        return r;
    endfunction

    function automatic st_t ph_leave(st_t s, logic din, cfg_t c);
        st_t  r;
        logic writing;
        r       = s;
        writing = (s.op != OP_READ);
        unique case (s.phase)
            PH_HALT:  r = ph_enter(s, PH_SETUP, c);
            PH_SETUP: r = ph_enter(s, writing ? PH_GAP : PH_LOW, c);
            PH_GAP:   r = ph_enter(s, PH_LOW, c);
            PH_LOW:
            begin
                if (!writing && din)
                begin
                    r.shift[s.bit_idx] = 1'b1;
                end
                r = ph_enter(r, PH_HIGH, c);
            end
            PH_HIGH:
            begin
                if (s.bit_idx == BIT_IDX_W'(BITS_PER_BYTE - 1))
                begin
                    r.bit_idx = '0;
                    r         = ph_enter(r, PH_HOLD, c);
                end
                else
                begin
                    r.bit_idx = s.bit_idx + 1'b1;
                    r         = ph_enter(r, writing ? PH_GAP : PH_LOW, c);
                end
            end
            PH_HOLD:
            begin
                if (s.op == OP_READ)
                begin
                    r.rx   = s.shift;
                    r.done = 1'b1;
                end
                if (s.bpos < BPOS_MAX)
                begin
                    r.bpos = s.bpos + 1'b1;
                end
                r.phase    = PH_IDLE;
                r.wait_cnt = '0;
            end
            default:
            begin
                r.phase    = PH_IDLE;
                r.wait_cnt = '0;
            end
        endcase
        return r;
    endfunction

    function automatic st_t ph_tick(st_t s, cmd_item_t it, cfg_t c);
        st_t r;
        r      = s;
        r.done = 1'b0;
        if (s.phase == PH_IDLE)
        begin
            unique case (it.kind)
                CMD_RELEASE:
                begin
                    r.en_pins = 1'b0;
                    r.en_data = 1'b0;
                    r.bpos    = '0;
                end
                CMD_ADDR:
                begin
                    if (!s.en_pins)
                    begin
                        r.lv_mode  = 1'b1;
                        r.lv_clock = 1'b1;
                        r.lv_data  = 1'b1;
                    end
                    r.en_pins = 1'b1;
                    r.en_data = 1'b1;
                    r.bpos    = '0;
                    r.op      = OP_ADDR;
                    r.shift   = it.byte_val;
                    r.bit_idx = '0;
                    r         = ph_enter(r, PH_SETUP, c);
                end
                CMD_WRITE, CMD_READ:
                begin
                    if (s.en_pins)
                    begin
                        if (it.kind == CMD_READ)
                        begin
                            r.en_data = 1'b0;
                            r.shift   = '0;
                            r.op      = OP_READ;
                        end
                        else
                        begin
                            r.en_data = 1'b1;
                            r.shift   = it.byte_val;
                            r.op      = OP_WRITE;
                        end
                        r.bit_idx = '0;
                        r = ph_enter(r, (s.bpos >= BPOS_MAX) ? PH_HALT : PH_SETUP, c);
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (s.wait_cnt > TIMER_WIDTH'(1))
        begin
            r.wait_cnt = s.wait_cnt - 1'b1;
        end
        else
        begin
            r = ph_leave(r, it.din, c);
        end
        return r;
    endfunction

    localparam cfg_t CFG_RESET = '{
        clock_low:  TIMER_WIDTH'(1),
        clock_high: TIMER_WIDTH'(1),
        mode_setup: TIMER_WIDTH'(1),
        mode_hold:  TIMER_WIDTH'(1),
        halt:       TIMER_WIDTH'(1),
        write_gap:  TIMER_WIDTH'(2)
    };

    localparam st_t ST_RESET = '{
        phase:    PH_IDLE,
        wait_cnt: '0,
        bit_idx:  '0,
        shift:    '0,
        bpos:     '0,
        op:       OP_ADDR,
        lv_mode:  1'b0,
        lv_clock: 1'b0,
        lv_data:  1'b0,
        en_pins:  1'b0,
        en_data:  1'b0,
        rx:       '0,
        done:     1'b0
    };

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    st_t       st_reg;
    st_t       st_next;
    logic      skip_reg;
    logic      skip_next;
    logic      din_reg;
    logic      din_next;
    logic      out_v_reg;
    logic      out_v_next;
    out_item_t out_reg;
    out_item_t out_next;
    st_t       step_st;
    logic      out_free;
    logic      step_en;
    logic      more;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CLOCK_LOW:  cfg_next.clock_low  = cfg_data[TIMER_WIDTH-1:0];
                REG_CLOCK_HIGH: cfg_next.clock_high = cfg_data[TIMER_WIDTH-1:0];
                REG_MODE_SETUP: cfg_next.mode_setup = cfg_data[TIMER_WIDTH-1:0];
                REG_MODE_HOLD:  cfg_next.mode_hold  = cfg_data[TIMER_WIDTH-1:0];
                REG_HALT:       cfg_next.halt       = cfg_data[TIMER_WIDTH-1:0];
                REG_WRITE_GAP:  cfg_next.write_gap  = cfg_data[TIMER_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign out_free = !out_v_reg || out_ch.ready;
    assign step_en  = out_free && (skip_reg || q_valid);
    assign q_pop    = out_free && !skip_reg && q_valid;

    // one phase exit per cycle while a zero-length phase is pending and the result register is free
    assign step_st = skip_reg ? ph_leave(st_reg, din_reg, cfg_reg)
                              : ph_tick(st_reg, q_item, cfg_reg);
    assign more    = (step_st.phase != PH_IDLE) && (step_st.wait_cnt == '0);

    always_comb
    begin
        st_next    = st_reg;
        skip_next  = skip_reg;
        din_next   = din_reg;
        out_next   = out_reg;
        out_v_next = out_v_reg && !out_ch.ready;
        if (step_en)
        begin
            st_next   = step_st;
            skip_next = more;
            if (!skip_reg)
            begin
                din_next = q_item.din;
            end
            if (!more)
            begin
                out_v_next           = 1'b1;
                out_next.mode_pin    = step_st.lv_mode;
                out_next.clock_pin   = step_st.lv_clock;
                out_next.data_pin    = step_st.lv_data;
                out_next.pins_driven = step_st.en_pins;
                out_next.data_driven = step_st.en_data;
                out_next.busy_res    = step_st.phase != PH_IDLE;
                out_next.read_done   = step_st.done;
                out_next.read_byte   = step_st.rx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg   <= CFG_RESET;
            st_reg    <= ST_RESET;
            skip_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            cfg_reg   <= cfg_next;
            st_reg    <= st_next;
            skip_reg  <= skip_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        din_reg <= din_next;
        out_reg <= out_next;
    end

    assign out_ch.valid = out_v_reg;
    assign out_ch.data  = out_reg;

endmodule

### sv/l3bm_checker.sv
// Port-level checker for the bus master, bound to the top level.
// Depends on l3bm_pkg, the channel interfaces and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module l3bm_checker
(
    input logic        clk,
    input logic        rst_n,
    l3bm_in_if.sink    in_ch,
    l3bm_out_if.source out_ch
);
    import l3bm_pkg::*;

    logic [INFLIGHT_W-1:0] inflight_reg;
    logic [INFLIGHT_W-1:0] inflight_next;
    logic                  in_fire;
    logic                  out_fire;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;

    // count tick beats taken but not yet answered
    always_comb
    begin
        inflight_next = inflight_reg + INFLIGHT_W'(in_fire) - INFLIGHT_W'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    `L3BM_ASSERT(a_inflight_cap, clk, rst_n, inflight_reg <= INFLIGHT_W'(INFLIGHT_MAX), "more beats in flight than storage")
    `L3BM_ASSERT(a_no_spurious_out, clk, rst_n, !out_ch.valid || (inflight_reg != '0), "result beat without a tick beat")
    `L3BM_ASSERT(a_ready_when_empty, clk, rst_n, (inflight_reg != '0) || in_ch.ready, "tick beat refused while empty")
    `L3BM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.data), "stalled result beat changed")

endmodule

bind l3_bus_master_unit l3bm_checker u_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
);
